// ----- design/subtitle_run_length_decoder_macros.svh -----
// Assertion macros used by the run emitter of the subtitle run-length decoder.
// Expects i_clk and i_rst_n in the scope of every use.
`ifndef SUBTITLE_RUN_LENGTH_DECODER_MACROS_SVH
`define SUBTITLE_RUN_LENGTH_DECODER_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define SRLD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SRLD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/srld_pkg.sv -----
// Package for the subtitle run-length decoder: types, code constants, widths.
// No dependencies; every other design file but the macros header imports it.
`timescale 1ns / 1ps

package srld_pkg;

    localparam int unsigned SRLD_BYTE_W    = 8;
    localparam int unsigned SRLD_POS_W     = 16;
    localparam int unsigned SRLD_LEN_W     = 14;
    localparam int unsigned SRLD_SHORT_W   = 6;
    localparam int unsigned SRLD_CFG_IDX_W = 1;
    localparam int unsigned SRLD_CFG_W     = 16;
    localparam int unsigned SRLD_Q_DEPTH   = 2;
    localparam int unsigned SRLD_Q_PTR_W   = 1;
    localparam int unsigned SRLD_Q_CNT_W   = 2;

    localparam logic [SRLD_POS_W-1:0] SRLD_WIDTH_RESET  = 16'd1920;
    localparam logic [SRLD_POS_W-1:0] SRLD_HEIGHT_RESET = 16'd1080;

    // Top two bits of the second byte of a zero-escaped code.
    localparam logic [1:0] SRLD_TOP_ZERO_SHORT = 2'b00;
    localparam logic [1:0] SRLD_TOP_ZERO_LONG  = 2'b01;
    localparam logic [1:0] SRLD_TOP_COL_SHORT  = 2'b10;
    localparam logic [1:0] SRLD_TOP_COL_LONG   = 2'b11;

    typedef enum logic [SRLD_CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        PH_FIRST     = 3'd0,
        PH_SECOND    = 3'd1,
        PH_ZERO_LOW  = 3'd2,
        PH_SHORT_COL = 3'd3,
        PH_LONG_LOW  = 3'd4,
        PH_LONG_COL  = 3'd5
    } t_phase;

    // One parsed code, handed from the parser to the run emitter.
    typedef struct packed {
        logic [SRLD_POS_W-1:0]  row;
        logic [SRLD_LEN_W-1:0]  len;
        logic [SRLD_BYTE_W-1:0] colour;
        logic                   eol;
        logic                   last;
    } t_cmd;

    // Queue status seen by the parser and the emitter.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// ----- design/srld_in_if.sv -----
// Byte channel into the subtitle run-length decoder.
// Depends on srld_pkg for field widths.
`timescale 1ns / 1ps

interface srld_in_if;
    import srld_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [SRLD_BYTE_W-1:0] code_byte;
    logic                   object_end;

    modport source (output valid, output code_byte, output object_end, input ready);
    modport sink   (input valid, input code_byte, input object_end, output ready);
endinterface

// ----- design/srld_out_if.sv -----
// Run command channel out of the subtitle run-length decoder.
// Depends on srld_pkg for field widths.
`timescale 1ns / 1ps

interface srld_out_if;
    import srld_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [SRLD_POS_W-1:0]  run_row;
    logic [SRLD_POS_W-1:0]  run_start;
    logic [SRLD_LEN_W-1:0]  run_length;
    logic [SRLD_BYTE_W-1:0] run_colour;
    logic                   object_done;

    modport source (output valid, output run_row, output run_start, output run_length,
                    output run_colour, output object_done, input ready);
    modport sink   (input valid, input run_row, input run_start, input run_length,
                    input run_colour, input object_done, output ready);
endinterface

// ----- design/srld_cmd_queue.sv -----
// Two-entry command queue between the code parser and the run emitter.
// Depends on srld_pkg.
`timescale 1ns / 1ps

module srld_cmd_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  srld_pkg::t_cmd    i_cmd,
    input  logic              i_pop,
    output srld_pkg::t_cmd    o_cmd,
    output srld_pkg::t_q_status o_status
);
    import srld_pkg::*;

    t_cmd                    r_mem [SRLD_Q_DEPTH];
    logic [SRLD_Q_PTR_W-1:0] r_wr_ptr;
    logic [SRLD_Q_PTR_W-1:0] r_rd_ptr;
    logic [SRLD_Q_CNT_W-1:0] r_count;
    logic [SRLD_Q_CNT_W-1:0] n_count;
    logic                    push_ok;
    logic                    pop_ok;

    assign o_status.full  = (r_count == SRLD_Q_CNT_W'(SRLD_Q_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign push_ok        = i_push && !o_status.full;
    assign pop_ok         = i_pop && !o_status.empty;
    assign o_cmd          = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (push_ok && !pop_ok) begin
            n_count = r_count + 1'b1;
        end else if (pop_ok && !push_ok) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (push_ok) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop_ok) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ----- design/srld_front.sv -----
// Code parser: takes coded bytes, tracks the code phase and the line, pushes a
// command per complete code or final byte. Depends on srld_pkg, srld_in_if.
`timescale 1ns / 1ps

module srld_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    srld_in_if.sink                         i_byte,
    input  logic [srld_pkg::SRLD_POS_W-1:0] i_image_height,
    input  srld_pkg::t_q_status             i_q_status,
    output logic                            o_push,
    output srld_pkg::t_cmd                  o_cmd
);
    import srld_pkg::*;

    t_phase                  r_phase;
    t_phase                  n_phase;
    logic [SRLD_SHORT_W-1:0] r_prefix;
    logic [SRLD_SHORT_W-1:0] n_prefix;
    logic [SRLD_LEN_W-1:0]   r_held_run;
    logic [SRLD_LEN_W-1:0]   n_held_run;
    logic [SRLD_POS_W-1:0]   r_line;
    logic [SRLD_POS_W-1:0]   n_line;
    logic                    accept;
    logic                    is_run;
    logic                    is_eol;
    logic [SRLD_BYTE_W-1:0]  b;

    assign i_byte.ready = !i_q_status.full;
    assign accept       = i_byte.valid && i_byte.ready;
    assign b            = i_byte.code_byte;

    always_comb begin
        n_phase      = r_phase;
        n_prefix     = r_prefix;
        n_held_run   = r_held_run;
        n_line       = r_line;
        is_run       = 1'b0;
        is_eol       = 1'b0;
        o_cmd.row    = r_line;
        o_cmd.len    = '0;
        o_cmd.colour = '0;
        o_cmd.eol    = 1'b0;
        o_cmd.last   = i_byte.object_end;
        if (accept) begin
            unique case (r_phase)
                PH_FIRST: begin
                    // Ignore codes that start below the last line.
                    if (r_line < i_image_height) begin
                        if (b != '0) begin
                            is_run       = 1'b1;
                            o_cmd.len    = SRLD_LEN_W'(1);
                            o_cmd.colour = b;
                        end else begin
                            n_phase = PH_SECOND;
                        end
                    end
                end
                PH_SECOND: begin
                    n_phase = PH_FIRST;
                    if (b == '0) begin
                        is_eol = 1'b1;
                        n_line = r_line + 1'b1;
                    end else begin
                        unique case (b[7:6])
                            SRLD_TOP_ZERO_LONG: begin
                                n_prefix = b[SRLD_SHORT_W-1:0];
                                n_phase  = PH_ZERO_LOW;
                            end
                            SRLD_TOP_COL_SHORT: begin
                                n_prefix = b[SRLD_SHORT_W-1:0];
                                n_phase  = PH_SHORT_COL;
                            end
                            SRLD_TOP_COL_LONG: begin
                                n_prefix = b[SRLD_SHORT_W-1:0];
                                n_phase  = PH_LONG_LOW;
                            end
                            SRLD_TOP_ZERO_SHORT: begin
                                is_run    = 1'b1;
                                o_cmd.len = SRLD_LEN_W'(b[SRLD_SHORT_W-1:0]);
                            end
                            default: begin
                                n_phase = PH_FIRST;
                            end
                        endcase
                    end
                end
                PH_ZERO_LOW: begin
                    n_phase   = PH_FIRST;
                    is_run    = 1'b1;
                    o_cmd.len = {r_prefix, b};
                end
                PH_SHORT_COL: begin
                    n_phase      = PH_FIRST;
                    is_run       = 1'b1;
                    o_cmd.len    = SRLD_LEN_W'(r_prefix);
                    o_cmd.colour = b;
                end
                PH_LONG_LOW: begin
                    n_held_run = {r_prefix, b};
                    n_phase    = PH_LONG_COL;
                end
                PH_LONG_COL: begin
                    n_phase      = PH_FIRST;
                    is_run       = 1'b1;
                    o_cmd.len    = r_held_run;
                    o_cmd.colour = b;
                end
                default: begin
                    n_phase = PH_FIRST;
                end
            endcase
            // Final byte: drop any partial code and start the next object clean.
            if (i_byte.object_end) begin
                n_phase    = PH_FIRST;
                n_prefix   = '0;
                n_held_run = '0;
                n_line     = '0;
            end
        end
        o_cmd.eol = is_eol;
        o_push    = accept && (is_run || is_eol || i_byte.object_end);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_FIRST;
            r_prefix   <= '0;
            r_held_run <= '0;
            r_line     <= '0;
        end else begin
            r_phase    <= n_phase;
            r_prefix   <= n_prefix;
            r_held_run <= n_held_run;
            r_line     <= n_line;
        end
    end

endmodule

// ----- design/srld_back.sv -----
// Run emitter: pops commands, tracks the column, clips runs to the width
// and holds each result in an output register. Depends on srld_pkg, srld_out_if.
`timescale 1ns / 1ps
`include "subtitle_run_length_decoder_macros.svh"

module srld_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  srld_pkg::t_cmd                  i_cmd,
    input  srld_pkg::t_q_status             i_q_status,
    input  logic [srld_pkg::SRLD_POS_W-1:0] i_image_width,
    output logic                            o_pop,
    srld_out_if.source                      o_run
);
    import srld_pkg::*;

    logic [SRLD_POS_W-1:0]  r_column;
    logic [SRLD_POS_W-1:0]  n_column;
    logic                   r_valid;
    logic                   n_valid;
    logic [SRLD_POS_W-1:0]  r_row;
    logic [SRLD_POS_W-1:0]  r_start;
    logic [SRLD_LEN_W-1:0]  r_length;
    logic [SRLD_BYTE_W-1:0] r_colour;
    logic                   r_done;
    logic [SRLD_POS_W-1:0]  room;
    logic [SRLD_LEN_W-1:0]  clipped;
    logic                   emit;

    assign o_pop = !i_q_status.empty && (!r_valid || o_run.ready);

    // Room left on the line; zero once the column reaches the width.
    assign room    = (r_column < i_image_width) ? (i_image_width - r_column) : '0;
    assign clipped = (SRLD_POS_W'(i_cmd.len) > room) ? room[SRLD_LEN_W-1:0] : i_cmd.len;
    assign emit    = !i_cmd.eol && (clipped != '0);

    always_comb begin
        n_column = r_column;
        n_valid  = r_valid && !o_run.ready;
        if (o_pop) begin
            n_valid = emit || i_cmd.last;
            if (i_cmd.last || i_cmd.eol) begin
                n_column = '0;
            end else if (emit) begin
                n_column = r_column + SRLD_POS_W'(clipped);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column <= '0;
            r_valid  <= 1'b0;
        end else begin
            r_column <= n_column;
            r_valid  <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_done <= i_cmd.last;
            if (emit) begin
                r_row    <= i_cmd.row;
                r_start  <= r_column;
                r_length <= clipped;
                r_colour <= i_cmd.colour;
            end else begin
                r_row    <= '0;
                r_start  <= '0;
                r_length <= '0;
                r_colour <= '0;
            end
        end
    end

    assign o_run.valid       = r_valid;
    assign o_run.run_row     = r_row;
    assign o_run.run_start   = r_start;
    assign o_run.run_length  = r_length;
    assign o_run.run_colour  = r_colour;
    assign o_run.object_done = r_done;

    `SRLD_ASSERT_SAME(a_empty_run_is_done, r_valid && (r_length == '0), r_done, "empty run without done")
    `SRLD_ASSERT_NEXT(a_column_cleared, o_pop && (i_cmd.last || i_cmd.eol), r_column == '0, "column not cleared")
    `SRLD_ASSERT_SAME(a_no_pop_when_stalled, r_valid && !o_run.ready, !o_pop, "pop over a held result")

endmodule

// ----- design/subtitle_run_length_decoder.sv -----
// Subtitle run-length decoder: takes one coded bitmap byte per item and
// returns clipped run commands; a parser feeds a two-entry command queue that
// feeds a run emitter with an output register. Depends on srld_pkg,
// srld_in_if, srld_out_if, srld_front, srld_cmd_queue, srld_back.
//
// The block takes one byte per clock unless the queue is full: the parser
// classifies a byte in the cycle it is accepted, and the emitter clips one
// command per cycle against the current column unless the output stalls. A
// stalled output holds its result while the queue keeps taking bytes until
// its two entries fill. Codes are the usual set: a nonzero
// byte is a single pixel; 00 00 ends a line; 00 0L, 00 4L LL, 00 8L CC and
// 00 CL LL CC are short or long runs of colour zero or of colour CC. Runs are
// cut at image_width, zero-length runs vanish, codes that start past
// image_height are skipped, and a code cut off by the final byte is dropped.
// The final byte of an object always yields one result with object_done set;
// when it completes no run, row, start, length and colour read zero. The
// consumer clears the bitmap before each object. Write configuration only
// while no bytes are in flight.
`timescale 1ns / 1ps

module subtitle_run_length_decoder (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    srld_in_if.sink                             i_byte,
    srld_out_if.source                          o_run,
    input  logic                                i_cfg_we,
    input  logic [srld_pkg::SRLD_CFG_IDX_W-1:0] i_cfg_index,
    input  logic [srld_pkg::SRLD_CFG_W-1:0]     i_cfg_data
);
    import srld_pkg::*;

    logic [SRLD_POS_W-1:0] r_image_width;
    logic [SRLD_POS_W-1:0] r_image_height;
    t_cmd                  push_cmd;
    t_cmd                  head_cmd;
    t_q_status             q_status;
    logic                  push;
    logic                  pop;

    // Configuration registers; hold until rewritten.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= SRLD_WIDTH_RESET;
            r_image_height <= SRLD_HEIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data;
                CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Parse bytes; advance the line on end-of-line codes.
    srld_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_byte         (i_byte),
        .i_image_height (r_image_height),
        .i_q_status     (q_status),
        .o_push         (push),
        .o_cmd          (push_cmd)
    );

    // Decouple the parser from output back-pressure.
    srld_cmd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (push_cmd),
        .i_pop    (pop),
        .o_cmd    (head_cmd),
        .o_status (q_status)
    );

    // Clip against the width and register each result.
    srld_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (head_cmd),
        .i_q_status    (q_status),
        .i_image_width (r_image_width),
        .o_pop         (pop),
        .o_run         (o_run)
    );

endmodule

// ----- test/testbench.sv -----
// Self-checking bench for the subtitle run-length decoder: drives coded bitmap
// bytes, predicts every run command and compares it field by field.
// Depends on srld_pkg, srld_in_if, srld_out_if and subtitle_run_length_decoder.
`timescale 1ns / 1ps

module testbench;
    import srld_pkg::*;

    // Result register sits behind the command queue; settle the pipeline
    // before touching the registers.
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned LONG_HOLD     = 300;
    localparam int unsigned SHOW_LIMIT    = 10;

    typedef struct packed {
        logic [SRLD_POS_W-1:0]  row;
        logic [SRLD_POS_W-1:0]  start;
        logic [SRLD_LEN_W-1:0]  run_length;
        logic [SRLD_BYTE_W-1:0] colour;
        logic                   done;
    } t_run_cmd;

    // How a directed row is judged: by the decoder model, by a value typed in, or not at all.
    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_NONE,
        CHK_RUN
    } t_check;

    typedef struct packed {
        logic [SRLD_BYTE_W-1:0] code;
        logic                   last;
        t_check                 chk;
        t_run_cmd               want;
    } t_vec;

    typedef struct packed {
        logic [SRLD_POS_W-1:0] width;
        logic [SRLD_POS_W-1:0] height;
        int unsigned           items;
        int unsigned           end_one_in;
        int unsigned           tx_pct;
        int unsigned           rx_pct;
    } t_sweep;

    localparam t_run_cmd NO_RUN = '0;

    // Directed bytes, decoded against the reset size 1920 x 1080. Every code
    // form appears at least once, plus clipping, zero lengths and the object's end.
    localparam t_vec DIRECTED [24] = '{
        '{8'hFF, 1'b0, CHK_RUN,   '{16'd0, 16'd0, 14'd1, 8'hFF, 1'b0}},   // single pixel
        '{8'h00, 1'b0, CHK_MODEL, NO_RUN},                                // end of line
        '{8'h00, 1'b0, CHK_MODEL, NO_RUN},
        '{8'h00, 1'b0, CHK_MODEL, NO_RUN},                                // short zero run
        '{8'h3F, 1'b0, CHK_RUN,   '{16'd1, 16'd0, 14'd63, 8'h00, 1'b0}},
        '{8'h00, 1'b0, CHK_MODEL, NO_RUN},                                // longest zero run,
        '{8'h7F, 1'b0, CHK_MODEL, NO_RUN},                                // cut at the width
        '{8'hFF, 1'b0, CHK_RUN,   '{16'd1, 16'd63, 14'd1857, 8'h00, 1'b0}},
        '{8'h00, 1'b0, CHK_MODEL, NO_RUN},                                // short colour run
        '{8'h80, 1'b0, CHK_MODEL, NO_RUN},                                // of length zero
        '{8'h12, 1'b0, CHK_NONE,  NO_RUN},
        '{8'h00, 1'b0, CHK_MODEL, NO_RUN},                                // end of line
        '{8'h00, 1'b0, CHK_MODEL, NO_RUN},
        '{8'h00, 1'b0, CHK_MODEL, NO_RUN},                                // short colour run
        '{8'hBF, 1'b0, CHK_MODEL, NO_RUN},
        '{8'hAB, 1'b0, CHK_RUN,   '{16'd2, 16'd0, 14'd63, 8'hAB, 1'b0}},
        '{8'h00, 1'b0, CHK_MODEL, NO_RUN},                                // longest colour run
        '{8'hFF, 1'b0, CHK_MODEL, NO_RUN},
        '{8'hFF, 1'b0, CHK_MODEL, NO_RUN},
        '{8'hFF, 1'b0, CHK_RUN,   '{16'd2, 16'd63, 14'd1857, 8'hFF, 1'b0}},
        '{8'h01, 1'b1, CHK_RUN,   '{16'd0, 16'd0, 14'd0, 8'h00, 1'b1}},   // line full: marker only
        '{8'h00, 1'b0, CHK_MODEL, NO_RUN},                                // code cut by the end
        '{8'hC5, 1'b1, CHK_RUN,   '{16'd0, 16'd0, 14'd0, 8'h00, 1'b1}},
        '{8'h80, 1'b1, CHK_RUN,   '{16'd0, 16'd0, 14'd1, 8'h80, 1'b1}}    // run on the final byte
    };

    // Random phases: register setting, item count, object length and idling.
    // Sender idles first lightly with a slow receiver, then the other way round,
    // then neither. Phases with no pixels left end objects often so results keep coming.
    localparam t_sweep SWEEP [8] = '{
        '{16'd16,    16'd4,     230, 40,  9, 62},
        '{16'd65535, 16'd65535, 230, 40,  9, 62},
        '{16'd0,     16'd5,     150,  4,  9, 62},
        '{16'd40,    16'd0,      40,  3, 62,  9},
        '{16'd7,     16'd3,     230, 40, 62,  9},
        '{16'd1,     16'd1,     200, 40, 62,  9},
        '{16'd300,   16'd20,    300, 40,  0,  0},
        '{16'd1920,  16'd1080,  370, 40,  0,  0}
    };

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_cfg_we;
    logic [SRLD_CFG_IDX_W-1:0]  i_cfg_index;
    logic [SRLD_CFG_W-1:0]      i_cfg_data;

    srld_in_if  byte_if ();
    srld_out_if run_if ();

    subtitle_run_length_decoder DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_byte      (byte_if),
        .o_run       (run_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Decoder state as the bench sees it.
    t_phase                 parse_phase;
    logic [SRLD_BYTE_W-1:0] esc_prefix;
    logic [SRLD_LEN_W-1:0]  long_run;
    logic [SRLD_POS_W-1:0]  cur_col;
    logic [SRLD_POS_W-1:0]  cur_line;
    logic [SRLD_POS_W-1:0]  cfg_width;
    logic [SRLD_POS_W-1:0]  cfg_height;

    t_run_cmd    pending_runs[$];
    int unsigned fail_count;
    int unsigned tx_idle_pct;
    int unsigned rx_idle_pct;
    bit          hold_request;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // ---------------------------------------------------------------- predictor

    function automatic void clear_object();
        parse_phase = PH_FIRST;
        esc_prefix  = '0;
        long_run    = '0;
        cur_col     = '0;
        cur_line    = '0;
    endfunction

    // Clip a run at the width and advance the column; 0 when nothing is left.
    function automatic bit clip_run(input logic [SRLD_LEN_W-1:0] n,
                                    input logic [SRLD_BYTE_W-1:0] colour,
                                    output t_run_cmd cmd);
        int unsigned room;
        int unsigned take;
        cmd  = '0;
        room = (cur_col < cfg_width) ? 32'(cfg_width - cur_col) : 0;
        take = (32'(n) > room) ? room : 32'(n);
        if (take == 0) return 1'b0;
        cmd.row        = cur_line;
        cmd.start      = cur_col;
        cmd.run_length = take[SRLD_LEN_W-1:0];
        cmd.colour     = colour;
        cur_col        = cur_col + take[SRLD_POS_W-1:0];
        return 1'b1;
    endfunction

    // Advance the parser by one byte; 1 when the byte yields a run command or end marker.
    function automatic bit decode_byte(input logic [SRLD_BYTE_W-1:0] b,
                                       input logic last, output t_run_cmd cmd);
        bit made;
        made = 1'b0;
        cmd  = '0;
        case (parse_phase)
            PH_FIRST: begin
                // Codes that start below the last line are skipped whole.
                if (cur_line < cfg_height) begin
                    if (b != 0) made = clip_run(SRLD_LEN_W'(1), b, cmd);
                    else parse_phase = PH_SECOND;
                end
            end
            PH_SECOND: begin
                parse_phase = PH_FIRST;
                if (b == 0) begin
                    cur_col  = '0;
                    cur_line = cur_line + 1'b1;
                end else begin
                    case (b[7:6])
                        SRLD_TOP_ZERO_LONG: begin
                            esc_prefix  = b;
                            parse_phase = PH_ZERO_LOW;
                        end
                        SRLD_TOP_COL_SHORT: begin
                            esc_prefix  = b;
                            parse_phase = PH_SHORT_COL;
                        end
                        SRLD_TOP_COL_LONG: begin
                            esc_prefix  = b;
                            parse_phase = PH_LONG_LOW;
                        end
                        default: made = clip_run({8'd0, b[5:0]}, 8'd0, cmd);
                    endcase
                end
            end
            PH_ZERO_LOW: begin
                parse_phase = PH_FIRST;
                made = clip_run({esc_prefix[5:0], b}, 8'd0, cmd);
            end
            PH_SHORT_COL: begin
                parse_phase = PH_FIRST;
                made = clip_run({8'd0, esc_prefix[5:0]}, b, cmd);
            end
            PH_LONG_LOW: begin
                long_run    = {esc_prefix[5:0], b};
                parse_phase = PH_LONG_COL;
            end
            PH_LONG_COL: begin
                parse_phase = PH_FIRST;
                made = clip_run(long_run, b, cmd);
            end
            default: parse_phase = PH_FIRST;
        endcase
        // The final byte always answers; with no run it is a bare marker.
        if (last) begin
            if (!made) cmd = '0;
            cmd.done = 1'b1;
            made     = 1'b1;
            clear_object();
        end
        return made;
    endfunction

    // ---------------------------------------------------------------- drivers

    // Offer one byte, idling at random first, and hold it until accepted.
    task automatic offer_byte(input logic [SRLD_BYTE_W-1:0] code, input logic last);
        while ($urandom_range(99) < tx_idle_pct) begin
            byte_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        byte_if.valid      <= 1'b1;
        byte_if.code_byte  <= code;
        byte_if.object_end <= last;
        do @(posedge i_clk); while (!byte_if.ready);
    endtask

    // Send a byte and queue what it should produce.
    task automatic take_byte(input logic [SRLD_BYTE_W-1:0] code, input logic last,
                             input t_check chk, input t_run_cmd want);
        t_run_cmd cmd;
        bit       made;
        offer_byte(code, last);
        made = decode_byte(code, last, cmd);
        case (chk)
            CHK_RUN:   pending_runs.push_back(want);
            CHK_NONE:  ;
            default:   if (made) pending_runs.push_back(cmd);
        endcase
    endtask

    // Drop valid and hold until every queued run has come back and the
    // pipeline has had time to finish bytes that give no result.
    task automatic wait_drained();
        byte_if.valid <= 1'b0;
        while (pending_runs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_regs(input logic [SRLD_POS_W-1:0] width,
                              input logic [SRLD_POS_W-1:0] height);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_IMAGE_WIDTH;
        i_cfg_data  <= width;
        @(posedge i_clk);
        cfg_width   = width;
        i_cfg_index <= CFG_IMAGE_HEIGHT;
        i_cfg_data  <= height;
        @(posedge i_clk);
        cfg_height  = height;
        i_cfg_we    <= 1'b0;
    endtask

    // Build one code with random content, mostly well formed, and send it.
    // Stop early if the object ends mid-code, which leaves it truncated.
    task automatic send_random_code(input int unsigned end_one_in, inout int unsigned counted);
        logic [SRLD_BYTE_W-1:0] seq[$];
        logic [SRLD_LEN_W-1:0]  n;
        logic [SRLD_BYTE_W-1:0] colour;
        logic                   last;
        int unsigned            kind;
        kind   = $urandom_range(0, 19);
        n      = ($urandom_range(0, 4) == 0) ? SRLD_LEN_W'($urandom)
                                              : SRLD_LEN_W'($urandom_range(0, 40));
        colour = SRLD_BYTE_W'($urandom);
        case (kind)
            0, 1, 2, 3, 4, 5: seq = '{SRLD_BYTE_W'($urandom_range(1, 255))};
            6, 7, 8:          seq = '{8'h00, 8'h00};
            9, 10:            seq = '{8'h00, {SRLD_TOP_ZERO_SHORT, 6'($urandom_range(1, 63))}};
            11, 12:           seq = '{8'h00, {SRLD_TOP_ZERO_LONG, n[13:8]}, n[7:0]};
            13, 14:           seq = '{8'h00, {SRLD_TOP_COL_SHORT, n[5:0]}, colour};
            15, 16:           seq = '{8'h00, {SRLD_TOP_COL_LONG, n[13:8]}, n[7:0], colour};
            default: begin
                // noise: a few bytes of anything
                repeat ($urandom_range(1, 3)) seq.push_back(SRLD_BYTE_W'($urandom));
            end
        endcase
        foreach (seq[i]) begin
            last = ($urandom_range(0, end_one_in - 1) == 0);
            take_byte(seq[i], last, CHK_MODEL, NO_RUN);
            counted++;
            if (last) break;
        end
    endtask

    // ---------------------------------------------------------------- receiver

    // Random back-pressure, plus one long hold-off on request that lets the
    // command queue fill and stall the byte input.
    initial begin
        int unsigned hold_left;
        hold_left    = 0;
        run_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                run_if.ready <= 1'b0;
            end else begin
                run_if.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Compare each accepted run with the oldest one still owed.
    always @(posedge i_clk) begin
        t_run_cmd got;
        t_run_cmd want;
        if (i_rst_n && run_if.valid && run_if.ready) begin
            got = '{run_if.run_row, run_if.run_start, run_if.run_length,
                    run_if.run_colour, run_if.object_done};
            if (pending_runs.size() == 0) begin
                fail_count++;
                if (fail_count <= SHOW_LIMIT)
                    $display("unexpected run: row %0d start %0d len %0d colour %0h done %0b",
                             got.row, got.start, got.run_length, got.colour, got.done);
            end else begin
                want = pending_runs.pop_front();
                if (got.row !== want.row || got.start !== want.start ||
                    got.run_length !== want.run_length || got.colour !== want.colour ||
                    got.done !== want.done) begin
                    fail_count++;
                    if (fail_count <= SHOW_LIMIT)
                        $display("run mismatch: want %0d/%0d/%0d/%0h/%0b got %0d/%0d/%0d/%0h/%0b",
                                 want.row, want.start, want.run_length, want.colour, want.done,
                                 got.row, got.start, got.run_length, got.colour, got.done);
                end
            end
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        bit          paused;
        int unsigned counted;
        fail_count         = 0;
        hold_request       = 1'b0;
        tx_idle_pct        = SWEEP[0].tx_pct;
        rx_idle_pct        = SWEEP[0].rx_pct;
        i_rst_n            <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_index        <= CFG_IMAGE_WIDTH;
        i_cfg_data         <= '0;
        byte_if.valid      <= 1'b0;
        byte_if.code_byte  <= '0;
        byte_if.object_end <= 1'b0;
        cfg_width          = SRLD_WIDTH_RESET;
        cfg_height         = SRLD_HEIGHT_RESET;
        clear_object();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part runs on the reset register values.
        foreach (DIRECTED[i])
            take_byte(DIRECTED[i].code, DIRECTED[i].last, DIRECTED[i].chk,
                      DIRECTED[i].want);
        wait_drained();

        // Random phases; objects may span a register change, so a lowered
        // width also catches a column already past the new edge.
        paused = 1'b0;
        foreach (SWEEP[p]) begin
            write_regs(SWEEP[p].width, SWEEP[p].height);
            tx_idle_pct = SWEEP[p].tx_pct;
            rx_idle_pct = SWEEP[p].rx_pct;
            if (p == 4) hold_request = 1'b1;
            counted = 0;
            while (counted < SWEEP[p].items) begin
                send_random_code(SWEEP[p].end_one_in, counted);
                // one pause mid-phase until the output side has caught up
                if (p == 5 && !paused && counted >= 100) begin
                    wait_drained();
                    paused = 1'b1;
                end
            end
            wait_drained();
        end

        fail_count += pending_runs.size();
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
